>>> hw/rtl/opp_pkg.sv
// Shared types and constants of the onset peak picker.
package opp_pkg;

    localparam int NOV_W   = 16;
    localparam int FRAME_W = 32;
    localparam int WIN_W   = 7;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] CFG_AVG_WINDOW  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_WINDOW  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_THRESHOLD   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RATIO_LIMIT = 3'd3;
    localparam logic [IDX_W-1:0] CFG_MIN_GAP     = 3'd4;
    localparam logic [IDX_W-1:0] CFG_NOISE_FLOOR = 3'd5;

    typedef struct packed {
        logic [WIN_W-1:0] avg_window;
        logic [WIN_W-1:0] max_window;
        logic [CFG_W-1:0] threshold;
        logic [CFG_W-1:0] ratio_limit;
        logic [CFG_W-1:0] min_gap;
        logic [CFG_W-1:0] noise_floor;
    } opp_cfg_t;

endpackage

>>> hw/rtl/onset_peak_picker_core.sv
// Top level of the onset peak picker: sequencer, window scan, shared multiplier, output.
//
//  Channel  Direction  Contents
//  s_       in         tdata[15:0] novelty
//  m_       out        tdata[31:0] peak_frame, tdata[47:32] peak_strength
//  cfg_     in         cfg_index selects a register, cfg_data is written to it
//
// After its acceptance an item is written to the history, then a window of L entries is scanned
// through the single history read port, where L is the larger of the two clamped window lengths.
// Three products then go through one shared multiplier, one per cycle, before the decision; no
// other item is accepted until the decision step is left.
// After reset a clearing pass writes zero to all WINDOW_DEPTH history entries, one per cycle,
// and no item is accepted meanwhile; configuration writes are taken at all times.
// A finished result waits in the output register; the next item is accepted meanwhile and
// only its own decision step, if it emits a peak, waits while that register is still full.
module onset_peak_picker_core #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,   // novelty
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [47:0]               m_tdata,   // peak_frame, peak_strength
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [opp_pkg::IDX_W-1:0] cfg_index,
    input  logic [opp_pkg::CFG_W-1:0] cfg_data
);
    import opp_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int SUM_W  = NOV_W + ADDR_W;
    localparam int PROD_W = NOV_W + SUM_W;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_WRITE  = 10'b00_0000_0100,
        ST_SCAN   = 10'b00_0000_1000,
        ST_LAST   = 10'b00_0001_0000,
        ST_MXN    = 10'b00_0010_0000,
        ST_MTN    = 10'b00_0100_0000,
        ST_MRS    = 10'b00_1000_0000,
        ST_CMP    = 10'b01_0000_0000,
        ST_DECIDE = 10'b10_0000_0000
    } state_t;

    opp_cfg_t cfg;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  write_slot_reg;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [CNT_W-1:0]   issue_cnt_reg;
    logic               pipe_vld_reg;
    logic [CNT_W-1:0]   pipe_k_reg;
    logic [NOV_W-1:0]   x_reg;
    logic [SUM_W-1:0]   window_sum_reg;
    logic [NOV_W-1:0]   max_reg;
    logic [PROD_W-1:0]  xn_reg;
    logic [PROD_W-1:0]  tn_reg;
    logic [PROD_W-1:0]  rs_reg;
    logic               lin_reg;
    logic               rat_reg;
    logic [FRAME_W-1:0] frame_count_reg;
    logic [FRAME_W-1:0] last_peak_reg;
    logic               have_peak_reg;
    logic               m_valid_reg, m_valid_next;
    logic [FRAME_W-1:0] m_frame_reg;
    logic [NOV_W-1:0]   m_strength_reg;

    logic [CNT_W-1:0]   n_avg;
    logic [CNT_W-1:0]   n_max;
    logic [CNT_W-1:0]   scan_len;
    logic [CMP_W-1:0]   avg_ext;
    logic [CMP_W-1:0]   max_ext;
    logic               hist_we;
    logic [ADDR_W-1:0]  hist_waddr;
    logic [NOV_W-1:0]   hist_wdata;
    logic [NOV_W-1:0]   hist_rdata;
    logic [NOV_W-1:0]   mul_a;
    logic [SUM_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W:0]    lin_rhs;
    logic [FRAME_W-1:0] frame_gap;
    logic               candidate;
    logic               emit;
    logic               out_free;
    logic               s_accept;
    logic               leave_decide;

    opp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    opp_hist #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_addr (hist_waddr),
        .wr_data (hist_wdata),
        .rd_addr (rd_addr_reg),
        .rd_data (hist_rdata)
    );

    always_comb begin
        avg_ext = CMP_W'(cfg.avg_window);
        max_ext = CMP_W'(cfg.max_window);
        if (avg_ext < CMP_W'(2)) begin
            n_avg = CNT_W'(2);
        end else if (avg_ext > CMP_W'(WINDOW_DEPTH)) begin
            n_avg = CNT_W'(WINDOW_DEPTH);
        end else begin
            n_avg = CNT_W'(avg_ext);
        end
        if (max_ext < CMP_W'(2)) begin
            n_max = CNT_W'(2);
        end else if (max_ext > CMP_W'(WINDOW_DEPTH)) begin
            n_max = CNT_W'(WINDOW_DEPTH);
        end else begin
            n_max = CNT_W'(max_ext);
        end
        scan_len = (n_avg > n_max) ? n_avg : n_max;
    end

    assign hist_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign hist_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : write_slot_reg;
    assign hist_wdata = (state_reg == ST_CLEAR) ? '0 : x_reg;

    always_comb begin
        case (state_reg)
            ST_MXN: begin
                mul_a = x_reg;
                mul_b = SUM_W'(n_avg);
            end
            ST_MTN: begin
                mul_a = cfg.threshold;
                mul_b = SUM_W'(n_avg);
            end
            default: begin
                mul_a = cfg.ratio_limit;
                mul_b = window_sum_reg;
            end
        endcase
    end

    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign lin_rhs = (PROD_W + 1)'(window_sum_reg) + (PROD_W + 1)'(tn_reg);

    assign frame_gap = frame_count_reg - last_peak_reg;
    assign candidate = (x_reg == max_reg) && (x_reg > cfg.noise_floor) && (lin_reg || rat_reg);
    assign emit      = candidate && (!have_peak_reg || (frame_gap > FRAME_W'(cfg.min_gap)));
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign leave_decide = (state_reg == ST_DECIDE) && (!emit || out_free);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(WINDOW_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_SCAN;
            ST_SCAN: begin
                if (issue_cnt_reg == scan_len - CNT_W'(1)) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:  state_next = ST_MXN;
            ST_MXN:   state_next = ST_MTN;
            ST_MTN:   state_next = ST_MRS;
            ST_MRS:   state_next = ST_CMP;
            ST_CMP:   state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (leave_decide) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (leave_decide && emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            write_slot_reg  <= '0;
            pipe_vld_reg    <= 1'b0;
            frame_count_reg <= '0;
            last_peak_reg   <= '0;
            have_peak_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            pipe_vld_reg <= (state_reg == ST_SCAN);
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (leave_decide) begin
                frame_count_reg <= frame_count_reg + FRAME_W'(1);
                if (write_slot_reg == ADDR_W'(WINDOW_DEPTH - 1)) begin
                    write_slot_reg <= '0;
                end else begin
                    write_slot_reg <= write_slot_reg + ADDR_W'(1);
                end
                if (emit) begin
                    last_peak_reg <= frame_count_reg;
                    have_peak_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg <= s_tdata;
        end
        pipe_k_reg <= issue_cnt_reg;
        case (state_reg)
            ST_WRITE: begin
                rd_addr_reg    <= write_slot_reg;
                issue_cnt_reg  <= '0;
                window_sum_reg <= '0;
                max_reg        <= '0;
            end
            ST_SCAN: begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                if (rd_addr_reg == '0) begin
                    rd_addr_reg <= ADDR_W'(WINDOW_DEPTH - 1);
                end else begin
                    rd_addr_reg <= rd_addr_reg - ADDR_W'(1);
                end
            end
            ST_MXN: xn_reg <= prod;
            ST_MTN: tn_reg <= prod;
            ST_MRS: rs_reg <= prod;
            ST_CMP: begin
                lin_reg <= (cfg.threshold != '0) && ((PROD_W + 1)'(xn_reg) > lin_rhs);
                rat_reg <= (cfg.ratio_limit != '0) && (window_sum_reg != '0) &&
                           ({xn_reg, 8'd0} > (PROD_W + 8)'(rs_reg));
            end
            default: begin
            end
        endcase
        if (pipe_vld_reg) begin
            if (pipe_k_reg < n_avg) begin
                window_sum_reg <= window_sum_reg + SUM_W'(hist_rdata);
            end
            if ((pipe_k_reg < n_max) && (hist_rdata > max_reg)) begin
                max_reg <= hist_rdata;
            end
        end
        if (leave_decide && emit) begin
            m_frame_reg    <= frame_count_reg;
            m_strength_reg <= x_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_strength_reg, m_frame_reg};

    a_max_covers_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (max_reg >= x_reg))
        else $error("window maximum below the current sample");

    a_scan_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg < scan_len))
        else $error("window scan ran past its length");

    a_emit_records_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        (leave_decide && emit) |=> (have_peak_reg && m_tvalid &&
                                    (last_peak_reg == $past(frame_count_reg))))
        else $error("emitted peak not recorded");

    a_frame_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        leave_decide |=> (frame_count_reg == $past(frame_count_reg) + FRAME_W'(1)))
        else $error("frame counter did not advance by one");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during history clearing");

endmodule

>>> hw/rtl/opp_cfg.sv
// Configuration register file of the onset peak picker.
module opp_cfg (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [opp_pkg::IDX_W-1:0] cfg_index,
    input  logic [opp_pkg::CFG_W-1:0] cfg_data,
    output opp_pkg::opp_cfg_t        cfg
);
    import opp_pkg::*;

    opp_cfg_t cfg_reg;
    opp_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_AVG_WINDOW:  cfg_next.avg_window  = cfg_data[WIN_W-1:0];
                CFG_MAX_WINDOW:  cfg_next.max_window  = cfg_data[WIN_W-1:0];
                CFG_THRESHOLD:   cfg_next.threshold   = cfg_data;
                CFG_RATIO_LIMIT: cfg_next.ratio_limit = cfg_data;
                CFG_MIN_GAP:     cfg_next.min_gap     = cfg_data;
                CFG_NOISE_FLOOR: cfg_next.noise_floor = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.avg_window  <= WIN_W'(17);
            cfg_reg.max_window  <= WIN_W'(5);
            cfg_reg.threshold   <= CFG_W'(13);
            cfg_reg.ratio_limit <= CFG_W'(4096);
            cfg_reg.min_gap     <= CFG_W'(5);
            cfg_reg.noise_floor <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/opp_hist.sv
// Sample history memory with one write port and one registered read port.
module opp_hist #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]   wr_addr,
    input  logic [opp_pkg::NOV_W-1:0]         wr_data,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]   rd_addr,
    output logic [opp_pkg::NOV_W-1:0]         rd_data
);
    import opp_pkg::*;

    logic [NOV_W-1:0] mem [WINDOW_DEPTH];
    logic [NOV_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> test/onset_peak_picker_core_tb.sv
`timescale 1ns / 1ps
// Testbench of the onset peak picker core: predicted onset peaks checked against the output stream.
module onset_peak_picker_core_tb;
    import opp_pkg::*;

    localparam int DEPTH       = 64;
    localparam int SETTLE      = 2 * (DEPTH + 8) + 16;
    localparam int LIMIT       = 1000000;
    localparam int PHASES      = 14;
    localparam int FIXED       = 5;
    localparam int PHASE_ITEMS = 135;
    localparam int HOLD_LEN    = 3000;

    localparam logic [IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        logic [NOV_W-1:0]   strength;
    } peak_t;

    class peak_tracker;
        logic [NOV_W-1:0]   history [DEPTH];
        int unsigned        slot;
        logic [FRAME_W-1:0] frame_count;
        logic [FRAME_W-1:0] last_peak;
        bit                 have_peak;
        opp_cfg_t           cfg;
        peak_t              pending_peaks [$];
        int                 errors;
        int                 samples;
        int                 peaks_seen;

        function new();
            foreach (history[i]) history[i] = '0;
            slot        = 0;
            frame_count = '0;
            last_peak   = '0;
            have_peak   = 1'b0;
            cfg.avg_window  = 7'd17;
            cfg.max_window  = 7'd5;
            cfg.threshold   = 16'd13;
            cfg.ratio_limit = 16'd4096;
            cfg.min_gap     = 16'd5;
            cfg.noise_floor = 16'd0;
            errors     = 0;
            samples    = 0;
            peaks_seen = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_AVG_WINDOW:  cfg.avg_window  = data[WIN_W-1:0];
                CFG_MAX_WINDOW:  cfg.max_window  = data[WIN_W-1:0];
                CFG_THRESHOLD:   cfg.threshold   = data;
                CFG_RATIO_LIMIT: cfg.ratio_limit = data;
                CFG_MIN_GAP:     cfg.min_gap     = data;
                CFG_NOISE_FLOOR: cfg.noise_floor = data;
                default: ;
            endcase
        endfunction

        function int unsigned span(logic [WIN_W-1:0] v);
            if (v < 2) return 2;
            if (v > DEPTH) return DEPTH;
            return v;
        endfunction

        function void take_sample(logic [NOV_W-1:0] x);
            int unsigned        n_avg;
            int unsigned        n_max;
            int unsigned        idx;
            longint unsigned    sum;
            longint unsigned    xn;
            longint unsigned    margin;
            longint unsigned    scaled;
            logic [NOV_W-1:0]   peak_val;
            logic [FRAME_W-1:0] frame_gap;
            bit                 lin;
            bit                 rat;
            peak_t              p;
            history[slot] = x;
            n_avg = span(cfg.avg_window);
            n_max = span(cfg.max_window);
            sum = 0;
            for (int k = 0; k < n_avg; k++) begin
                idx = (slot + DEPTH - k) % DEPTH;
                sum += history[idx];
            end
            peak_val = '0;
            for (int k = 0; k < n_max; k++) begin
                idx = (slot + DEPTH - k) % DEPTH;
                if (history[idx] > peak_val) peak_val = history[idx];
            end
            if (x == peak_val && x > cfg.noise_floor) begin
                xn     = longint'(x) * n_avg;
                margin = longint'(cfg.threshold) * n_avg;
                scaled = longint'(cfg.ratio_limit) * sum;
                lin = (cfg.threshold != 0) && (xn > sum + margin);
                rat = (cfg.ratio_limit != 0) && (sum > 0) && (xn * 256 > scaled);
                if (lin || rat) begin
                    frame_gap = frame_count - last_peak;
                    if (!have_peak || frame_gap > {16'd0, cfg.min_gap}) begin
                        p.frame    = frame_count;
                        p.strength = x;
                        pending_peaks.push_back(p);
                        last_peak = frame_count;
                        have_peak = 1'b1;
                    end
                end
            end
            slot = (slot + 1) % DEPTH;
            frame_count++;
            samples++;
        endfunction

        function void match_peak(logic [FRAME_W-1:0] frame, logic [NOV_W-1:0] strength);
            peak_t p;
            peaks_seen++;
            if (pending_peaks.size() == 0) begin
                $error("Unexpected peak transaction: frame %0d strength %0d", frame, strength);
                errors++;
                return;
            end
            p = pending_peaks.pop_front();
            if (frame !== p.frame) begin
                $error("peak_frame: expected %0d, actual %0d", p.frame, frame);
                errors++;
            end
            if (strength !== p.strength) begin
                $error("peak_strength: expected %0d, actual %0d", p.strength, strength);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [47:0]       m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    peak_tracker tracker;
    int          hold_cycles = 0;
    bit          no_idle     = 1'b0;
    int          cycle_count = 0;

    onset_peak_picker_core #(
        .WINDOW_DEPTH(DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic send_sample(input logic [NOV_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_sample(value);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.set_reg(index, data);
    endtask

    task automatic apply_config(input opp_cfg_t c);
        write_reg(CFG_AVG_WINDOW, {9'($urandom), c.avg_window});
        write_reg(CFG_MAX_WINDOW, {9'($urandom), c.max_window});
        write_reg(CFG_THRESHOLD, c.threshold);
        write_reg(CFG_RATIO_LIMIT, c.ratio_limit);
        write_reg(CFG_MIN_GAP, c.min_gap);
        write_reg(CFG_NOISE_FLOOR, c.noise_floor);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_peaks();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_peaks.size() != 0);
    endtask

    task automatic settle();
        wait_for_peaks();
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic opp_cfg_t fixed_config(int phase);
        opp_cfg_t c;
        case (phase)
            0: c = '{avg_window: 7'd0, max_window: 7'd1, threshold: 16'd0,
                     ratio_limit: 16'd1, min_gap: 16'd0, noise_floor: 16'd0};
            1: c = '{avg_window: 7'd127, max_window: 7'd127, threshold: 16'hFFFF,
                     ratio_limit: 16'd0, min_gap: 16'd3, noise_floor: 16'd0};
            2: c = '{avg_window: 7'd65, max_window: 7'd100, threshold: 16'd1,
                     ratio_limit: 16'd0, min_gap: 16'hFFFF, noise_floor: 16'd0};
            3: c = '{avg_window: 7'd2, max_window: 7'd2, threshold: 16'd1,
                     ratio_limit: 16'hFFFF, min_gap: 16'd1, noise_floor: 16'hFFFF};
            default: c = '{avg_window: 7'd64, max_window: 7'd64, threshold: 16'd200,
                           ratio_limit: 16'd512, min_gap: 16'd0, noise_floor: 16'd300};
        endcase
        return c;
    endfunction

    function automatic opp_cfg_t random_config();
        opp_cfg_t c;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 70)      c.avg_window = 7'($urandom_range(2, 20));
        else if (r < 85) c.avg_window = 7'($urandom_range(21, 64));
        else             c.avg_window = 7'($urandom_range(0, 127));
        r = $urandom_range(0, 99);
        if (r < 70)      c.max_window = 7'($urandom_range(2, 8));
        else if (r < 85) c.max_window = 7'($urandom_range(9, 64));
        else             c.max_window = 7'($urandom_range(0, 127));
        r = $urandom_range(0, 99);
        if (r < 20)      c.threshold = 16'd0;
        else if (r < 90) c.threshold = 16'($urandom_range(0, 3000));
        else             c.threshold = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 20)      c.ratio_limit = 16'd0;
        else if (r < 90) c.ratio_limit = 16'($urandom_range(128, 8192));
        else             c.ratio_limit = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 80)      c.min_gap = 16'($urandom_range(0, 24));
        else if (r < 95) c.min_gap = 16'($urandom_range(25, 500));
        else             c.min_gap = 16'hFFFF;
        r = $urandom_range(0, 99);
        if (r < 40)      c.noise_floor = 16'd0;
        else if (r < 90) c.noise_floor = 16'($urandom_range(0, 600));
        else             c.noise_floor = 16'($urandom);
        return c;
    endfunction

    // Mostly a quiet curve with sparse onset spikes, plus some fully random samples.
    function automatic logic [NOV_W-1:0] random_novelty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'($urandom);
        if (r < 22) return 16'($urandom_range(1500, 65535));
        return 16'($urandom_range(0, 400));
    endfunction

    initial begin
        int sink_gap;
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            sink_gap = no_idle ? 0 : $urandom_range(0, 3);
            if (sink_gap > 0) begin
                m_tready <= 1'b0;
                repeat (sink_gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            tracker.match_peak(m_tdata[31:0], m_tdata[47:32]);
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles.", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [NOV_W-1:0] directed [$];
        opp_cfg_t         c;
        tracker = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: silence, full-scale peaks close together, single-bit levels, silence, full scale.
        directed = '{16'd0, 16'hFFFF, 16'hFFFF};
        for (int b = 0; b < NOV_W; b++) directed.push_back(16'(1) << b);
        directed.push_back(16'd0);
        directed.push_back(16'hFFFF);
        foreach (directed[i]) send_sample(directed[i]);
        settle();

        write_reg(CFG_UNUSED_6, 16'($urandom));
        write_reg(CFG_UNUSED_7, 16'($urandom));
        for (int phase = 0; phase < PHASES; phase++) begin
            c = (phase < FIXED) ? fixed_config(phase) : random_config();
            apply_config(c);
            no_idle = (phase == 6) || (phase == 8);
            if (phase == 6) hold_cycles = HOLD_LEN;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (phase == 7 && i == 60) wait_for_peaks();
                send_sample(random_novelty());
            end
            settle();
        end

        if (tracker.pending_peaks.size() != 0) begin
            $error("%0d expected peaks never arrived", tracker.pending_peaks.size());
            tracker.errors++;
        end
        $display("Sent %0d novelty samples over %0d register settings; %0d peaks checked.",
                 tracker.samples, PHASES + 1, tracker.peaks_seen);
        $display("Covered clamped windows, disabled tests, noise floor, gap limits and stalls.");
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> onset_peak_picker_core.f
hw/rtl/opp_pkg.sv
hw/rtl/opp_cfg.sv
hw/rtl/opp_hist.sv
hw/rtl/onset_peak_picker_core.sv
test/onset_peak_picker_core_tb.sv
